// File: rtl/vfdfs_pkg.sv
// ---------------------------------------------------------------------------
// vfdfs_pkg: shared types and constants of the frame store grid scanner
// Item layouts, action codes and the controller/datapath command and status.
// ---------------------------------------------------------------------------
package vfdfs_pkg;

  localparam int unsigned RowsDef    = 64;
  localparam int unsigned ColumnsDef = 128;
  localparam int unsigned LastGrid   = 42;

  // column / 3 as (column * DivMul) >> DivShift, exact for 8-bit columns
  localparam int unsigned DivMul   = 171;
  localparam int unsigned DivShift = 9;

  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_SCAN  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] column;
    logic [7:0] row_or_page;
    logic       show;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0] grid_index;
    logic [5:0] row_index;
    logic [5:0] anode_bits;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_CLEAR,
    MEM_PIX_RD,
    MEM_PIX_WR,
    MEM_BYTE_WR,
    MEM_SCAN_RD
  } mem_op_e;

  typedef struct packed {
    mem_op_e mem_op;
    logic    scan_next;
    logic    out_load;
    logic    row_inc;
    logic    row_clr;
    logic    grid_adv;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       pix_ok;
    logic       byte_ok;
    logic       clr_last;
    logic       row_last;
    logic       row_page_end;
    logic       out_free;
  } status_t;

endpackage

// File: rtl/vfdfs_in_if.sv
// ---------------------------------------------------------------------------
// vfdfs_in_if: input word channel
// Valid/ready handshake carrying one command word.
// ---------------------------------------------------------------------------
interface vfdfs_in_if
  import vfdfs_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/vfdfs_out_if.sv
// ---------------------------------------------------------------------------
// vfdfs_out_if: output word channel
// Valid/ready handshake carrying one anode row word.
// ---------------------------------------------------------------------------
interface vfdfs_out_if
  import vfdfs_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/vfdfs_ram.sv
// ---------------------------------------------------------------------------
// vfdfs_ram: generic single-port ram
// One access per cycle, write or read, read data registered.
// ---------------------------------------------------------------------------
module vfdfs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/vfdfs_ctrl.sv
// ---------------------------------------------------------------------------
// vfdfs_ctrl: sequencer of the frame store grid scanner
// Clears the store after reset, runs pixel read-modify-write, byte writes
// and the row-by-row scan of one grid.
// ---------------------------------------------------------------------------
module vfdfs_ctrl
  import vfdfs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PIX   = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mem_op = MEM_NONE;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_op = MEM_CLEAR;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (status_i.action)
            ACT_PIXEL: begin
              if (status_i.pix_ok) begin
                cmd_o.mem_op = MEM_PIX_RD;
                state_d      = ST_PIX;
              end
            end
            ACT_BYTE: begin
              if (status_i.byte_ok) begin
                cmd_o.mem_op = MEM_BYTE_WR;
              end
            end
            ACT_SCAN: begin
              cmd_o.mem_op = MEM_SCAN_RD;
              state_d      = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_PIX: begin
        cmd_o.mem_op = MEM_PIX_WR;
        state_d      = ST_IDLE;
      end
      ST_SCAN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.row_last) begin
            cmd_o.row_clr  = 1'b1;
            cmd_o.grid_adv = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.row_inc = 1'b1;
            // fetch the next page while the last row of this one goes out
            if (status_i.row_page_end) begin
              cmd_o.mem_op    = MEM_SCAN_RD;
              cmd_o.scan_next = 1'b1;
            end
          end
        end
      end
    endcase
  end

endmodule

// File: rtl/vfdfs_datapath.sv
// ---------------------------------------------------------------------------
// vfdfs_datapath: frame store banks, counters and output register
// The store is split into three banks by column mod 3, addressed by
// {column / 3, page}, so one grid reads one byte from each bank per page.
// ---------------------------------------------------------------------------
module vfdfs_datapath
  import vfdfs_pkg::*;
#(
  parameter int unsigned ROWS    = RowsDef,
  parameter int unsigned COLUMNS = ColumnsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned RW     = $clog2(ROWS);
  localparam int unsigned PAGES  = (ROWS + 7) / 8;
  localparam int unsigned PW     = (RW > 3) ? RW - 3 : 1;
  localparam int unsigned GROUPS = (COLUMNS + 2) / 3;
  localparam int unsigned GW     = $clog2(GROUPS);
  localparam int unsigned DEPTH  = GROUPS << PW;
  localparam int unsigned AW     = GW + PW;

  // live decode of the offered word
  logic [15:0]   div_prod;
  logic [6:0]    col_div3;
  logic [7:0]    col_rem_full;
  logic [1:0]    col_bank;
  logic          col_ok;
  logic [AW-1:0] pix_addr, byte_addr;

  assign div_prod     = 16'(in_data_i.column) * 16'(DivMul);
  assign col_div3     = div_prod[15:DivShift];
  assign col_rem_full = in_data_i.column - ((8'(col_div3) << 1) + 8'(col_div3));
  assign col_bank     = col_rem_full[1:0];
  assign col_ok       = in_data_i.column < 8'(COLUMNS);
  assign pix_addr     = {GW'(col_div3), PW'(in_data_i.row_or_page >> 3)};
  assign byte_addr    = {GW'(col_div3), PW'(in_data_i.row_or_page)};

  // pixel read-modify-write capture
  logic [AW-1:0] cap_addr_q;
  logic [1:0]    cap_bank_q;
  logic [2:0]    cap_bit_q;
  logic          cap_show_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_op == MEM_PIX_RD) begin
      cap_addr_q <= pix_addr;
      cap_bank_q <= col_bank;
      cap_bit_q  <= in_data_i.row_or_page[2:0];
      cap_show_q <= in_data_i.show;
    end
  end

  // counters
  logic [AW-1:0] clr_q;
  logic [RW-1:0] row_q;
  logic [5:0]    grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      row_q  <= '0;
      grid_q <= '0;
    end else begin
      if (cmd_i.mem_op == MEM_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.row_clr) begin
        row_q <= '0;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + RW'(1);
      end
      if (cmd_i.grid_adv) begin
        grid_q <= (grid_q >= 6'(LastGrid)) ? 6'd0 : grid_q + 6'd1;
      end
    end
  end

  // scan address
  logic          grp_ok;
  logic [RW-1:0] row_page_cur, row_page_nxt;
  logic [PW-1:0] scan_page;
  logic [AW-1:0] scan_addr;

  assign grp_ok       = grid_q < 6'(GROUPS);
  assign row_page_cur = row_q >> 3;
  assign row_page_nxt = row_page_cur + RW'(1);
  assign scan_page    = cmd_i.scan_next ? PW'(row_page_nxt) : PW'(row_page_cur);
  assign scan_addr    = grp_ok ? {GW'(grid_q), scan_page} : '0;

  // banks
  logic [7:0]    rdata [3];
  logic [2:0]    ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    old_byte, bit_mask;

  always_comb begin
    unique case (cap_bank_q)
      2'd0:    old_byte = rdata[0];
      2'd1:    old_byte = rdata[1];
      2'd2:    old_byte = rdata[2];
      default: old_byte = '0;
    endcase
  end

  assign bit_mask = 8'd1 << cap_bit_q;

  always_comb begin
    ram_en    = '0;
    ram_we    = '0;
    ram_addr  = '0;
    ram_wdata = '0;
    unique case (cmd_i.mem_op)
      MEM_CLEAR: begin
        ram_en   = '1;
        ram_we   = '1;
        ram_addr = clr_q;
      end
      MEM_PIX_RD: begin
        ram_en   = '1;
        ram_addr = pix_addr;
      end
      MEM_PIX_WR: begin
        ram_en    = 3'b001 << cap_bank_q;
        ram_we    = 3'b001 << cap_bank_q;
        ram_addr  = cap_addr_q;
        ram_wdata = cap_show_q ? (old_byte | bit_mask) : (old_byte & ~bit_mask);
      end
      MEM_BYTE_WR: begin
        ram_en    = 3'b001 << col_bank;
        ram_we    = 3'b001 << col_bank;
        ram_addr  = byte_addr;
        ram_wdata = in_data_i.data_byte;
      end
      MEM_SCAN_RD: begin
        ram_en   = '1;
        ram_addr = scan_addr;
      end
      default: ;
    endcase
  end

  for (genvar b = 0; b < 3; b++) begin : g_bank
    vfdfs_ram #(
      .Width (8),
      .Depth (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .en_i    (ram_en[b]),
      .we_i    (ram_we[b]),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata),
      .rdata_o (rdata[b])
    );
  end

  // anode bit interleave
  logic [2:0] row_bit;
  logic       p0, p1, p2;
  logic [5:0] anode;

  assign row_bit = row_q[2:0];
  assign p0      = grp_ok & rdata[0][row_bit];
  assign p1      = grp_ok & rdata[1][row_bit];
  assign p2      = grp_ok & rdata[2][row_bit];

  always_comb begin
    priority if (grid_q >= 6'(LastGrid)) begin
      anode = {p0, 1'b0, p1, 3'b000};
    end else if (!grid_q[0]) begin
      anode = {p0, 1'b0, p1, 1'b0, p2, 1'b0};
    end else begin
      anode = {1'b0, p2, 1'b0, p1, 1'b0, p0};
    end
  end

  // output register
  logic      out_valid_q;
  out_item_t out_data_q;
  logic      row_last;

  assign row_last = row_q == RW'(ROWS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.grid_index <= grid_q;
      out_data_q.row_index  <= 6'(row_q);
      out_data_q.anode_bits <= anode;
      out_data_q.last       <= row_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign status_o.action       = in_data_i.action;
  assign status_o.pix_ok       = col_ok && (in_data_i.row_or_page < 8'(ROWS));
  assign status_o.byte_ok      = col_ok && (in_data_i.row_or_page < 8'(PAGES));
  assign status_o.clr_last     = clr_q == AW'(DEPTH - 1);
  assign status_o.row_last     = row_last;
  assign status_o.row_page_end = row_bit == 3'd7;
  assign status_o.out_free     = !out_valid_q || out_ready_i;

endmodule

// File: rtl/vfd_frame_store_grid_scanner.sv
// ---------------------------------------------------------------------------
// vfd_frame_store_grid_scanner: one-bit frame store with grid scan output
// Pixel and column-page writes into the store; a scan word emits one anode
// word per row for the current grid, then steps the grid 0..42.
// ---------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  in_i    | in  | valid/ready | action, column, row_or_page, show, data_byte
//  out_o   | out | valid/ready | grid_index, row_index, anode_bits, last
//
//  byte write: a single write; pixel write: a read, then a write back.
//  scan: a read of the first page, then one row per cycle while out_o is not
//  stalled, out of the registered bank reads, next page fetched during a row.
//  after reset a clearing pass zeroes the store, one address per cycle over
//  all three banks in parallel: ceil(COLUMNS/3) * 8 = 344 entries by default.
//  a stalled out_o holds the scan; input is taken only between words.
// ---------------------------------------------------------------------------
module vfd_frame_store_grid_scanner
  import vfdfs_pkg::*;
#(
  parameter int unsigned ROWS    = RowsDef,
  parameter int unsigned COLUMNS = ColumnsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  vfdfs_in_if.sink     in_i,
  vfdfs_out_if.source  out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  vfdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vfdfs_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

  assign in_i.ready = in_ready;

endmodule
